FILE: hdl/lc3x_pkg.sv
// Package for the LC-3 execute unit: item kinds, opcodes, sequencer states,
// result layout and the small helper functions for immediates and flags.
// No dependencies.
`timescale 1ns / 1ps

package lc3x_pkg;

    // Item kinds, carried on s_tuser
    localparam logic [1:0] KIND_EXEC   = 2'd0;
    localparam logic [1:0] KIND_MEM_WR = 2'd1;
    localparam logic [1:0] KIND_MEM_RD = 2'd2;
    localparam logic [1:0] KIND_REG_RD = 2'd3;

    // Opcodes, instruction bits 15..12
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_RTI  = 4'd8;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_RSV  = 4'd13;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    // Condition codes
    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    localparam logic [15:0] START_PC_RESET = 16'h3000;
    localparam logic [2:0]  LINK_REG       = 3'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REGB,
        ST_EXEC,
        ST_MEM1,
        ST_MEM2,
        ST_DONE
    } seq_state_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic        illegal;
        logic [15:0] read_word;
        logic        mem_write_done;
        logic [15:0] dest_value;
        logic [2:0]  dest_index;
        logic        reg_write_done;
        logic [2:0]  cond_flags;
        logic [15:0] next_pc;
    } result_t;

    function automatic logic [15:0] sext5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

    function automatic logic [15:0] sext6(input logic [5:0] v);
        return {{10{v[5]}}, v};
    endfunction

    function automatic logic [15:0] sext9(input logic [8:0] v);
        return {{7{v[8]}}, v};
    endfunction

    function automatic logic [15:0] sext11(input logic [10:0] v);
        return {{5{v[10]}}, v};
    endfunction

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'd0) begin
            f = CC_Z;
        end else if (v[15]) begin
            f = CC_N;
        end else begin
            f = CC_P;
        end
        return f;
    endfunction

endpackage

FILE: hdl/lc3_execute_unit.sv
// Top level of the LC-3 execute unit: sequencer, register file and word memory.
// Depends on lc3x_pkg and lc3x_ram.
//
//  channel | direction | handshake          | content
//  --------+-----------+--------------------+------------------------------------
//  s_      | in        | s_tvalid/s_tready  | one item: kind, instruction, ...
//  m_      | out       | m_tvalid/m_tready  | one result per item
//  cfg_    | in        | cfg_valid/cfg_ready| start_pc, loads the PC at once
//
// An item passes from acceptance through REGB, EXEC and DONE to its result (loads,
// STI and memory reads add MEM1, LDI also MEM2): two register file reads and up to
// two dependent word memory reads, each through a RAM with registered read data.
// A new item is taken once the previous one has moved into the output register.
// Synchronous active-low reset clears the register file valid bits, loads the
// PC with 0x3000 and sets the Z flag; the word memory holds nothing defined
// until written.
`timescale 1ns / 1ps

module lc3_execute_unit #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // instruction[15:0], address[31:16], data[47:32],
                                   // reg_select[50:48], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // next_pc[15:0], cond_flags[18:16],
                                   // reg_write_done[19], dest_index[22:20],
                                   // dest_value[38:23], mem_write_done[39],
                                   // read_word[55:40], illegal[56], zero pad
    // configuration transaction
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    import lc3x_pkg::*;

    seq_state_t state_reg, state_next;

    // latched item
    logic [1:0]  kind_reg;
    logic [15:0] ins_reg;
    logic [15:0] addr_reg;
    logic [15:0] data_reg;
    logic [2:0]  rsel_reg;

    // architectural state outside the RAMs
    logic [15:0] pc_reg;
    logic [2:0]  cc_reg;
    logic [7:0]  rf_valid_reg;
    logic        rf_rd_valid_reg;

    // operands
    logic [15:0] a_reg, b_reg;
    logic [15:0] rf_value;

    // pending result
    logic [15:0] res_pc_reg,  res_pc_next;
    logic        res_wr_reg,  res_wr_next;
    logic [2:0]  res_di_reg,  res_di_next;
    logic [15:0] res_val_reg, res_val_next;
    logic        res_mw_reg,  res_mw_next;
    logic [15:0] res_rw_reg,  res_rw_next;
    logic        res_ill_reg, res_ill_next;
    logic        res_cc_reg,  res_cc_next;

    // output register
    logic    out_valid_reg;
    result_t out_reg;

    // RAM ports
    logic                     rf_we, rf_re;
    logic [2:0]               rf_waddr, rf_raddr;
    logic [15:0]              rf_wdata, rf_rd_data;
    logic                     mem_we, mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [15:0]              mem_wdata, mem_rd_data;

    // decode
    logic        s_accept, commit;
    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic [15:0] pc_inc, pc_off9, base_off6;
    logic        op_illegal, exec_mem_rd;
    logic [2:0]  cc_next;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign commit = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    assign op        = ins_reg[15:12];
    assign dr        = ins_reg[11:9];
    assign sr1       = ins_reg[8:6];
    assign pc_inc    = pc_reg + 16'd1;
    assign pc_off9   = pc_inc + sext9(ins_reg[8:0]);
    assign base_off6 = a_reg + sext6(ins_reg[5:0]);
    assign rf_value  = rf_rd_valid_reg ? rf_rd_data : 16'd0;

    assign op_illegal = (op == OP_RTI) || (op == OP_RSV) || (op == OP_TRAP);

    // items that go through a word memory read after the execute step
    assign exec_mem_rd = (kind_reg == KIND_MEM_RD) ||
                         ((kind_reg == KIND_EXEC) &&
                          ((op == OP_LD) || (op == OP_LDR) ||
                           (op == OP_LDI) || (op == OP_STI)));

    assign cc_next = res_cc_reg ? flags_of(res_val_reg) : cc_reg;

    // register file, entries read as zero until first written
    lc3x_ram #(
        .WIDTH(16),
        .DEPTH(8)
    ) u_regfile (
        .aclk    (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (rf_re),
        .rd_addr (rf_raddr),
        .rd_data (rf_rd_data)
    );

    // word memory
    lc3x_ram #(
        .WIDTH(16),
        .DEPTH(2 ** MEM_ADDR_BITS)
    ) u_wordmem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_REGB;
                end
            end
            ST_REGB: state_next = ST_EXEC;
            ST_EXEC: begin
                if (exec_mem_rd) begin
                    state_next = ST_MEM1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MEM1: begin
                if ((kind_reg == KIND_EXEC) && (op == OP_LDI)) begin
                    state_next = ST_MEM2;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MEM2: state_next = ST_DONE;
            ST_DONE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and pending result
    always_comb begin
        rf_re     = 1'b0;
        rf_raddr  = 3'd0;
        rf_we     = 1'b0;
        rf_waddr  = res_di_reg;
        rf_wdata  = res_val_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = b_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;

        res_pc_next  = res_pc_reg;
        res_wr_next  = res_wr_reg;
        res_di_next  = res_di_reg;
        res_val_next = res_val_reg;
        res_mw_next  = res_mw_reg;
        res_rw_next  = res_rw_reg;
        res_ill_next = res_ill_reg;
        res_cc_next  = res_cc_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // first operand: base/source register, or the probed register
                rf_re = s_accept;
                if (s_tuser == KIND_REG_RD) begin
                    rf_raddr = s_tdata[50:48];
                end else begin
                    rf_raddr = s_tdata[8:6];
                end
            end
            ST_REGB: begin
                // second operand: store source, or SR2
                rf_re = 1'b1;
                if ((op == OP_ST) || (op == OP_STI) || (op == OP_STR)) begin
                    rf_raddr = dr;
                end else begin
                    rf_raddr = ins_reg[2:0];
                end
            end
            ST_EXEC: begin
                res_pc_next  = pc_reg;
                res_wr_next  = 1'b0;
                res_di_next  = 3'd0;
                res_val_next = 16'd0;
                res_mw_next  = 1'b0;
                res_rw_next  = 16'd0;
                res_ill_next = 1'b0;
                res_cc_next  = 1'b0;
                mem_wdata    = rf_value;
                unique case (kind_reg)
                    KIND_MEM_WR: begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_reg[MEM_ADDR_BITS-1:0];
                        mem_wdata = data_reg;
                    end
                    KIND_MEM_RD: begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_reg[MEM_ADDR_BITS-1:0];
                    end
                    KIND_REG_RD: begin
                        res_di_next  = rsel_reg;
                        res_val_next = a_reg;
                    end
                    default: begin
                        if (op_illegal) begin
                            res_ill_next = 1'b1;
                        end else begin
                            res_pc_next = pc_inc;
                            unique case (op)
                                OP_ADD, OP_AND: begin
                                    logic [15:0] opb;
                                    opb = ins_reg[5] ? sext5(ins_reg[4:0]) : rf_value;
                                    res_val_next = (op == OP_ADD) ? (a_reg + opb)
                                                                  : (a_reg & opb);
                                    res_wr_next = 1'b1;
                                    res_di_next = dr;
                                    res_cc_next = 1'b1;
                                end
                                OP_NOT: begin
                                    res_val_next = ~a_reg;
                                    res_wr_next  = 1'b1;
                                    res_di_next  = dr;
                                    res_cc_next  = 1'b1;
                                end
                                OP_LEA: begin
                                    res_val_next = pc_off9;
                                    res_wr_next  = 1'b1;
                                    res_di_next  = dr;
                                    res_cc_next  = 1'b1;
                                end
                                OP_BR: begin
                                    if ((dr & cc_reg) != 3'd0) begin
                                        res_pc_next = pc_off9;
                                    end
                                end
                                OP_JMP: res_pc_next = a_reg;
                                OP_JSR: begin
                                    // link written after the base register was read
                                    res_pc_next = ins_reg[11]
                                        ? (pc_inc + sext11(ins_reg[10:0])) : a_reg;
                                    res_wr_next  = 1'b1;
                                    res_di_next  = LINK_REG;
                                    res_val_next = pc_inc;
                                end
                                OP_LD, OP_LDI, OP_STI: begin
                                    mem_re    = 1'b1;
                                    mem_raddr = pc_off9[MEM_ADDR_BITS-1:0];
                                    if (op != OP_STI) begin
                                        res_wr_next = 1'b1;
                                        res_di_next = dr;
                                        res_cc_next = 1'b1;
                                    end else begin
                                        res_mw_next = 1'b1;
                                    end
                                end
                                OP_LDR: begin
                                    mem_re      = 1'b1;
                                    mem_raddr   = base_off6[MEM_ADDR_BITS-1:0];
                                    res_wr_next = 1'b1;
                                    res_di_next = dr;
                                    res_cc_next = 1'b1;
                                end
                                OP_ST: begin
                                    mem_we      = 1'b1;
                                    mem_waddr   = pc_off9[MEM_ADDR_BITS-1:0];
                                    res_mw_next = 1'b1;
                                end
                                OP_STR: begin
                                    mem_we      = 1'b1;
                                    mem_waddr   = base_off6[MEM_ADDR_BITS-1:0];
                                    res_mw_next = 1'b1;
                                end
                                default: res_ill_next = 1'b1;
                            endcase
                        end
                    end
                endcase
            end
            ST_MEM1: begin
                if (kind_reg == KIND_MEM_RD) begin
                    res_rw_next = mem_rd_data;
                end else if (op == OP_LDI) begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_rd_data[MEM_ADDR_BITS-1:0];
                end else if (op == OP_STI) begin
                    mem_we    = 1'b1;
                    mem_waddr = mem_rd_data[MEM_ADDR_BITS-1:0];
                end else begin
                    res_val_next = mem_rd_data;
                end
            end
            ST_MEM2: res_val_next = mem_rd_data;
            ST_DONE: rf_we = commit && res_wr_reg;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= START_PC_RESET;
            cc_reg        <= CC_Z;
            rf_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                pc_reg <= cfg_data;
            end else if (commit) begin
                pc_reg <= res_pc_reg;
            end
            if (commit) begin
                cc_reg <= cc_next;
            end
            if (rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg <= s_tuser;
            ins_reg  <= s_tdata[15:0];
            addr_reg <= s_tdata[31:16];
            data_reg <= s_tdata[47:32];
            rsel_reg <= s_tdata[50:48];
        end
        if (rf_re) begin
            rf_rd_valid_reg <= rf_valid_reg[rf_raddr];
        end
        if (state_reg == ST_REGB) begin
            a_reg <= rf_value;
        end
        if (state_reg == ST_EXEC) begin
            b_reg <= rf_value;
        end
        res_pc_reg  <= res_pc_next;
        res_wr_reg  <= res_wr_next;
        res_di_reg  <= res_di_next;
        res_val_reg <= res_val_next;
        res_mw_reg  <= res_mw_next;
        res_rw_reg  <= res_rw_next;
        res_ill_reg <= res_ill_next;
        res_cc_reg  <= res_cc_next;
        if (commit) begin
            out_reg.next_pc        <= res_pc_reg;
            out_reg.cond_flags     <= cc_next;
            out_reg.reg_write_done <= res_wr_reg;
            out_reg.dest_index     <= res_di_reg;
            out_reg.dest_value     <= res_val_reg;
            out_reg.mem_write_done <= res_mw_reg;
            out_reg.read_word      <= res_rw_reg;
            out_reg.illegal        <= res_ill_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule

FILE: hdl/lc3x_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lc3x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
